// ===== rtl/core/nea_pkg.sv =====
// Shared types, constants and helpers for the normal equations accumulator.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package nea_pkg;

  // Fixed field widths and element counts of one input row.
  localparam int ElemW   = 16;
  localparam int ProdW   = 2 * ElemW;
  localparam int AccW    = 48;
  localparam int AFields = 4;
  localparam int BFields = 2;

  // Defaults for the top-level size parameters.
  localparam int MaxUnknownsDef = 4;
  localparam int MaxRhsDef      = 2;

  // Item modes.
  localparam logic [1:0] ModeAcc  = 2'd0;
  localparam logic [1:0] ModeClr  = 2'd1;
  localparam logic [1:0] ModeDump = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CfgRows = 2'd0;
  localparam logic [1:0] CfgCols = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [2:0] RowsReset = 3'd4;
  localparam logic [1:0] ColsReset = 2'd2;

  // Position and marking of one dumped entry.
  typedef struct packed {
    logic       which;
    logic [1:0] row;
    logic [1:0] col;
    logic       last;
  } dump_pos_t;

  // Turns a raw count register into an active count: zero acts as one, and
  // the count saturates at the given limit.
  function automatic logic [2:0] clamp_count(input logic [2:0] raw, input logic [2:0] limit);
    logic [2:0] n;
    n = raw;
    if (n == 3'd0) begin
      n = 3'd1;
    end
    if (n > limit) begin
      n = limit;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nea_lane.sv =====
// One multiply-accumulate lane: registered product and a saturating 48-bit sum.
// Depends on nea_pkg for widths.
`default_nettype none

module nea_lane (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic                                clr_i,
  input  wire logic signed [nea_pkg::ElemW-1:0]    a_i,
  input  wire logic signed [nea_pkg::ElemW-1:0]    b_i,
  output logic signed [nea_pkg::AccW-1:0]          acc_o
);

  localparam int SumW = nea_pkg::AccW + 1;
  localparam logic signed [nea_pkg::AccW-1:0] AccMax = {1'b0, {(nea_pkg::AccW-1){1'b1}}};
  localparam logic signed [nea_pkg::AccW-1:0] AccMin = {1'b1, {(nea_pkg::AccW-1){1'b0}}};

  logic signed [nea_pkg::ProdW-1:0] prod_q;
  logic                             pvld_q;
  logic signed [nea_pkg::AccW-1:0]  acc_q;
  logic signed [nea_pkg::AccW-1:0]  acc_d;
  logic signed [SumW-1:0]           sum;

  // Product stage: the multiplier output is registered before the add.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  // Saturating accumulate. A clear arrives after any pending product, so it wins.
  always_comb begin
    sum = SumW'(acc_q) + SumW'(prod_q);
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (pvld_q) begin
      if (sum[SumW-1] != sum[SumW-2]) begin
        acc_d = sum[SumW-1] ? AccMin : AccMax;
      end else begin
        acc_d = sum[nea_pkg::AccW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ===== rtl/core/nea_dump.sv =====
// Merging stage: walks the active entries of both stores and registers them
// onto the result channel. Depends on nea_pkg for widths and the position struct.
`default_nettype none

module nea_dump (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [2:0]                         nr_i,
  input  wire logic [1:0]                         nc_i,
  input  wire logic signed [nea_pkg::AccW-1:0]    ata_val_i [0:3][0:3],
  input  wire logic signed [nea_pkg::AccW-1:0]    atb_val_i [0:3][0:1],
  input  wire logic                               out_ready_i,
  output logic                                    busy_o,
  output logic                                    out_valid_o,
  output logic signed [nea_pkg::AccW-1:0]         value_o,
  output nea_pkg::dump_pos_t                      pos_o
);

  logic                            busy_q, busy_d;
  logic                            which_q, which_d;
  logic [1:0]                      row_q, row_d;
  logic [1:0]                      col_q, col_d;
  logic                            ovld_q, ovld_d;
  logic signed [nea_pkg::AccW-1:0] value_q;
  nea_pkg::dump_pos_t              pos_q;
  logic                            emit;
  logic [2:0]                      limit;
  logic                            col_last;
  logic                            row_last;
  logic signed [nea_pkg::AccW-1:0] sel_val;

  // One entry leaves per cycle whenever the output register is free or drains.
  assign emit     = busy_q && (!ovld_q || out_ready_i);
  assign limit    = which_q ? {1'b0, nc_i} : nr_i;
  assign col_last = (3'(col_q) + 3'd1) == limit;
  assign row_last = (3'(row_q) + 3'd1) == nr_i;
  assign sel_val  = which_q ? atb_val_i[row_q][col_q[0]] : ata_val_i[row_q][col_q];

  // Row-major walk, first over A-transpose-A, then over A-transpose-B.
  always_comb begin
    busy_d  = busy_q;
    which_d = which_q;
    row_d   = row_q;
    col_d   = col_q;
    if (start_i) begin
      busy_d  = 1'b1;
      which_d = 1'b0;
      row_d   = '0;
      col_d   = '0;
    end else if (emit) begin
      if (col_last) begin
        col_d = '0;
        if (row_last) begin
          row_d = '0;
          if (which_q) begin
            busy_d = 1'b0;
          end else begin
            which_d = 1'b1;
          end
        end else begin
          row_d = row_q + 2'd1;
        end
      end else begin
        col_d = col_q + 2'd1;
      end
    end
  end

  // Output register valid flag.
  always_comb begin
    ovld_d = ovld_q;
    if (emit) begin
      ovld_d = 1'b1;
    end else if (out_ready_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      which_q <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      which_q <= which_d;
      row_q   <= row_d;
      col_q   <= col_d;
      ovld_q  <= ovld_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      value_q     <= sel_val;
      pos_q.which <= which_q;
      pos_q.row   <= row_q;
      pos_q.col   <= col_q;
      pos_q.last  <= which_q && row_last && col_last;
    end
  end

  assign busy_o      = busy_q;
  assign out_valid_o = ovld_q;
  assign value_o     = value_q;
  assign pos_o       = pos_q;

endmodule

`default_nettype wire

// ===== rtl/core/normal_equations_accumulator.sv =====
// Top level of the normal equations accumulator: configuration, lane array and dump stage.
// Depends on nea_pkg, nea_lane and nea_dump.
//
//   Channel   Direction  Handshake               Carries
//   in        input      in_valid_i/in_ready_o   mode, four A elements, two B elements
//   out       output     out_valid_o/out_ready_i entry value, store, row, column, last flag
//   cfg       input      cfg_valid_i/cfg_ready_o register index, write data
//
// A new row is accepted every cycle while no dump is in progress.
// Each row runs through a product register and then the saturating add of its lane.
// A dump holds off new input from the accepting cycle until its last entry is registered.
// Entries move one per cycle into the single output register while that register is empty
// or being taken; each cycle in which it is full and not taken holds the walk.
// Reset zeroes both stores and loads 4 rows and 2 columns into the configuration registers.
`default_nettype none

module normal_equations_accumulator #(
  parameter int MAX_UNKNOWNS = nea_pkg::MaxUnknownsDef,
  parameter int MAX_RHS      = nea_pkg::MaxRhsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      mode_i,
  input  wire logic signed [nea_pkg::ElemW-1:0] a_elem0_i,
  input  wire logic signed [nea_pkg::ElemW-1:0] a_elem1_i,
  input  wire logic signed [nea_pkg::ElemW-1:0] a_elem2_i,
  input  wire logic signed [nea_pkg::ElemW-1:0] a_elem3_i,
  input  wire logic signed [nea_pkg::ElemW-1:0] b_elem0_i,
  input  wire logic signed [nea_pkg::ElemW-1:0] b_elem1_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [nea_pkg::AccW-1:0]      entry_value_o,
  output logic                                 which_store_o,
  output logic [1:0]                           entry_row_o,
  output logic [1:0]                           entry_col_o,
  output logic                                 last_entry_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [1:0]                      cfg_index_i,
  input  wire logic [2:0]                      cfg_data_i
);

  // Lanes that can ever be active.
  localparam int NR = (MAX_UNKNOWNS < nea_pkg::AFields) ? MAX_UNKNOWNS : nea_pkg::AFields;
  localparam int NC = (MAX_RHS < nea_pkg::BFields) ? MAX_RHS : nea_pkg::BFields;

  logic [2:0]                      rows_q;
  logic [1:0]                      cols_q;
  logic [2:0]                      nr;
  logic [1:0]                      nc;
  logic                            in_acc;
  logic                            acc_en;
  logic                            clr;
  logic                            dump_start;
  logic                            busy;
  logic signed [nea_pkg::ElemW-1:0] a_vec [0:3];
  logic signed [nea_pkg::ElemW-1:0] b_vec [0:1];
  logic signed [nea_pkg::AccW-1:0]  ata_val [0:3][0:3];
  logic signed [nea_pkg::AccW-1:0]  atb_val [0:3][0:1];
  nea_pkg::dump_pos_t               pos;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= nea_pkg::RowsReset;
      cols_q <= nea_pkg::ColsReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == nea_pkg::CfgRows) begin
        rows_q <= cfg_data_i;
      end else if (cfg_index_i == nea_pkg::CfgCols) begin
        cols_q <= cfg_data_i[1:0];
      end
    end
  end

  // Active counts.
  assign nr = nea_pkg::clamp_count(rows_q, 3'(NR));
  assign nc = 2'(nea_pkg::clamp_count({1'b0, cols_q}, 3'(NC)));

  // Input transaction decode; a dump in progress holds off new items.
  assign in_ready_o = !busy;
  assign in_acc     = in_valid_i && in_ready_o;
  assign acc_en     = in_acc && (mode_i == nea_pkg::ModeAcc);
  assign clr        = in_acc && (mode_i == nea_pkg::ModeClr);
  assign dump_start = in_acc && (mode_i == nea_pkg::ModeDump);

  assign a_vec[0] = a_elem0_i;
  assign a_vec[1] = a_elem1_i;
  assign a_vec[2] = a_elem2_i;
  assign a_vec[3] = a_elem3_i;
  assign b_vec[0] = b_elem0_i;
  assign b_vec[1] = b_elem1_i;

  // Lane array: one lane per store entry, enabled when its row and column are active.
  for (genvar i = 0; i < nea_pkg::AFields; i++) begin : g_row
    for (genvar j = 0; j < nea_pkg::AFields; j++) begin : g_ata
      if (i < NR && j < NR) begin : g_lane
        nea_lane u_lane (
          .clk_i  (clk_i),
          .rst_ni (rst_ni),
          .en_i   (acc_en && (3'(i) < nr) && (3'(j) < nr)),
          .clr_i  (clr),
          .a_i    (a_vec[i]),
          .b_i    (a_vec[j]),
          .acc_o  (ata_val[i][j])
        );
      end else begin : g_none
        assign ata_val[i][j] = '0;
      end
    end
    for (genvar j = 0; j < nea_pkg::BFields; j++) begin : g_atb
      if (i < NR && j < NC) begin : g_lane
        nea_lane u_lane (
          .clk_i  (clk_i),
          .rst_ni (rst_ni),
          .en_i   (acc_en && (3'(i) < nr) && (2'(j) < nc)),
          .clr_i  (clr),
          .a_i    (a_vec[i]),
          .b_i    (b_vec[j]),
          .acc_o  (atb_val[i][j])
        );
      end else begin : g_none
        assign atb_val[i][j] = '0;
      end
    end
  end

  // Dump sequencer and result register.
  nea_dump u_dump (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (dump_start),
    .nr_i        (nr),
    .nc_i        (nc),
    .ata_val_i   (ata_val),
    .atb_val_i   (atb_val),
    .out_ready_i (out_ready_i),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .value_o     (entry_value_o),
    .pos_o       (pos)
  );

  assign which_store_o = pos.which;
  assign entry_row_o   = pos.row;
  assign entry_col_o   = pos.col;
  assign last_entry_o  = pos.last;

endmodule

`default_nettype wire

// ===== tb/normal_equations_accumulator_tb.sv =====
// Self-checking testbench for normal_equations_accumulator: directed rows, a short run at
// two unknowns, then random rows over several register settings, checked by a predictor.
// Depends on nea_pkg and the normal_equations_accumulator RTL.
module normal_equations_accumulator_tb;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam logic [1:0] CfgUnused  = 2'd3;
  localparam int RowLimit = (nea_pkg::MaxUnknownsDef < nea_pkg::AFields) ?
                            nea_pkg::MaxUnknownsDef : nea_pkg::AFields;
  localparam int ColLimit = (nea_pkg::MaxRhsDef < nea_pkg::BFields) ?
                            nea_pkg::MaxRhsDef : nea_pkg::BFields;
  localparam longint SumMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SumMin = -SumMax - 1;
  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 8;
  localparam int DirectedCount = 14;
  localparam int PhaseCount    = 8;
  localparam int RowsPerPhase  = 14;

  // One input transaction; a pinned row carries a value every dumped entry must show.
  typedef struct packed {
    logic [1:0]       mode;
    logic [3:0][15:0] a;
    logic [1:0][15:0] b;
    logic             pinned;
    logic [47:0]      pin_value;
  } row_item_t;

  typedef struct packed {
    logic [47:0] value;
    logic        which;
    logic [1:0]  row;
    logic [1:0]  col;
    logic        last;
  } dump_entry_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] mode_i = nea_pkg::ModeAcc;
  logic signed [nea_pkg::ElemW-1:0] a_elem0_i = '0;
  logic signed [nea_pkg::ElemW-1:0] a_elem1_i = '0;
  logic signed [nea_pkg::ElemW-1:0] a_elem2_i = '0;
  logic signed [nea_pkg::ElemW-1:0] a_elem3_i = '0;
  logic signed [nea_pkg::ElemW-1:0] b_elem0_i = '0;
  logic signed [nea_pkg::ElemW-1:0] b_elem1_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [nea_pkg::AccW-1:0] entry_value_o;
  logic which_store_o;
  logic [1:0] entry_row_o;
  logic [1:0] entry_col_o;
  logic last_entry_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = nea_pkg::CfgRows;
  logic [2:0] cfg_data_i = '0;

  normal_equations_accumulator uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .mode_i(mode_i),
    .a_elem0_i(a_elem0_i), .a_elem1_i(a_elem1_i), .a_elem2_i(a_elem2_i),
    .a_elem3_i(a_elem3_i), .b_elem0_i(b_elem0_i), .b_elem1_i(b_elem1_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .entry_value_o(entry_value_o), .which_store_o(which_store_o),
    .entry_row_o(entry_row_o), .entry_col_o(entry_col_o), .last_entry_o(last_entry_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // Predictor state: both stores and the raw register contents.
  longint ata_sum [nea_pkg::AFields][nea_pkg::AFields];
  longint atb_sum [nea_pkg::AFields][nea_pkg::BFields];
  logic [2:0] rows_raw = nea_pkg::RowsReset;
  logic [1:0] cols_raw = nea_pkg::ColsReset;

  dump_entry_t dump_fifo [$];
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  logic [7:0] stall_tick = '0;
  row_item_t directed_rows [DirectedCount];
  logic [2:0] phase_rows [PhaseCount] = '{3'd0, 3'd7, 3'd1, 3'd3, 3'd2, 3'd5, 3'd4, 3'd1};
  logic [1:0] phase_cols [PhaseCount] = '{2'd0, 2'd3, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2, 2'd2};

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int active_count(int raw, int limit);
    int n;
    n = (raw == 0) ? 1 : raw;
    return (n > limit) ? limit : n;
  endfunction

  function automatic longint add_clamped(longint acc, longint p);
    longint s;
    s = acc + p;
    if (s > SumMax) return SumMax;
    if (s < SumMin) return SumMin;
    return s;
  endfunction

  function automatic row_item_t mk_row(logic [1:0] mode, logic [15:0] a0, logic [15:0] a1,
                                       logic [15:0] a2, logic [15:0] a3, logic [15:0] b0,
                                       logic [15:0] b1, logic pinned, logic [47:0] pin);
    row_item_t it;
    it.mode = mode;
    it.a = {a3, a2, a1, a0};
    it.b = {b1, b0};
    it.pinned = pinned;
    it.pin_value = pin;
    return it;
  endfunction

  // Extremes and sign-boundary values show up often, the rest is uniform.
  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic row_item_t rand_row();
    int pick;
    logic [1:0] mode;
    pick = $urandom_range(0, 99);
    if (pick < 75) mode = nea_pkg::ModeAcc;
    else if (pick < 87) mode = nea_pkg::ModeDump;
    else if (pick < 94) mode = nea_pkg::ModeClr;
    else mode = ModeUnused;
    return mk_row(mode, rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                  rand_elem(), rand_elem(), 1'b0, '0);
  endfunction

  // Apply one accepted row to the predicted stores and queue the entries a dump emits.
  task automatic predict_row(row_item_t it);
    int nr;
    int nc;
    int k;
    int total;
    longint av [nea_pkg::AFields];
    longint bv [nea_pkg::BFields];
    dump_entry_t e;
    nr = active_count(int'(rows_raw), RowLimit);
    nc = active_count(int'(cols_raw), ColLimit);
    case (it.mode)
      nea_pkg::ModeAcc: begin
        for (int i = 0; i < nea_pkg::AFields; i++) av[i] = longint'($signed(it.a[i]));
        for (int j = 0; j < nea_pkg::BFields; j++) bv[j] = longint'($signed(it.b[j]));
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nr; j++) ata_sum[i][j] = add_clamped(ata_sum[i][j], av[i] * av[j]);
          for (int j = 0; j < nc; j++) atb_sum[i][j] = add_clamped(atb_sum[i][j], av[i] * bv[j]);
        end
      end
      nea_pkg::ModeClr: begin
        foreach (ata_sum[i, j]) ata_sum[i][j] = 0;
        foreach (atb_sum[i, j]) atb_sum[i][j] = 0;
      end
      nea_pkg::ModeDump: begin
        total = nr * nr + nr * nc;
        k = 0;
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nr; j++) begin
            e.value = it.pinned ? it.pin_value : ata_sum[i][j][47:0];
            e.which = 1'b0;
            e.row = 2'(i);
            e.col = 2'(j);
            e.last = (k == total - 1);
            dump_fifo.push_back(e);
            k++;
          end
        end
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            e.value = it.pinned ? it.pin_value : atb_sum[i][j][47:0];
            e.which = 1'b1;
            e.row = 2'(i);
            e.col = 2'(j);
            e.last = (k == total - 1);
            dump_fifo.push_back(e);
            k++;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Present one row and hold it until the transaction completes.
  task automatic put_row(row_item_t it);
    mode_i <= it.mode;
    a_elem0_i <= it.a[0];
    a_elem1_i <= it.a[1];
    a_elem2_i <= it.a[2];
    a_elem3_i <= it.a[3];
    b_elem0_i <= it.b[0];
    b_elem1_i <= it.b[1];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_row(it);
  endtask

  // Sender bursts: keep valid high inside a burst, drop it for a random gap between.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // Stop sending and wait until every queued entry is out and the pipeline has settled.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (dump_fifo.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] index, logic [2:0] data);
    drain();
    cfg_index_i <= index;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (index == nea_pkg::CfgRows) rows_raw = data;
    else if (index == nea_pkg::CfgCols) cols_raw = data[1:0];
  endtask

  task automatic note_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
  endtask

  // Receiver: rotates through always-ready, random, sparse and long-stall patterns.
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 8'd1;
    case (stall_tick[7:6])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= 1'($urandom_range(0, 1));
      2'd2: out_ready_i <= (stall_tick[1:0] == 2'd0);
      default: out_ready_i <= stall_tick[3];
    endcase
  end

  // Compare each output transaction with the oldest predicted entry.
  always @(posedge clk_i) begin
    dump_entry_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (dump_fifo.size() == 0) begin
        note_mismatch("unexpected entry value", longint'(entry_value_o), 0);
      end else begin
        want = dump_fifo.pop_front();
        if (entry_value_o !== want.value)
          note_mismatch("entry_value", longint'(entry_value_o), longint'($signed(want.value)));
        if (which_store_o !== want.which)
          note_mismatch("which_store", longint'(which_store_o), longint'(want.which));
        if (entry_row_o !== want.row)
          note_mismatch("entry_row", longint'(entry_row_o), longint'(want.row));
        if (entry_col_o !== want.col)
          note_mismatch("entry_col", longint'(entry_col_o), longint'(want.col));
        if (last_entry_o !== want.last)
          note_mismatch("last_entry", longint'(last_entry_o), longint'(want.last));
      end
    end
  end

  // Watchdog: counts cycles in which no channel completes a transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("normal_equations_accumulator test failed");
    $finish;
  end

  // Main stimulus sequence.
  initial begin
    row_item_t it;
    foreach (ata_sum[i, j]) ata_sum[i][j] = 0;
    foreach (atb_sum[i, j]) atb_sum[i][j] = 0;

    // Directed rows at the reset setting of four unknowns and two right-hand sides.
    directed_rows[0]  = mk_row(nea_pkg::ModeDump, '0, '0, '0, '0, '0, '0, 1'b1, 48'd0);
    directed_rows[1]  = mk_row(nea_pkg::ModeAcc, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                               16'h8000, 16'h8000, 1'b0, '0);
    directed_rows[2]  = mk_row(nea_pkg::ModeDump, '0, '0, '0, '0, '0, '0, 1'b1,
                               48'd1073741824);
    directed_rows[3]  = mk_row(nea_pkg::ModeAcc, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                               16'h7FFF, 16'h7FFF, 1'b0, '0);
    directed_rows[4]  = mk_row(nea_pkg::ModeDump, '0, '0, '0, '0, '0, '0, 1'b0, '0);
    directed_rows[5]  = mk_row(nea_pkg::ModeClr, 16'h1234, 16'h8000, 16'h7FFF, 16'hFFFF,
                               16'h0001, 16'h5555, 1'b0, '0);
    directed_rows[6]  = mk_row(nea_pkg::ModeDump, '0, '0, '0, '0, '0, '0, 1'b1, 48'd0);
    directed_rows[7]  = mk_row(nea_pkg::ModeAcc, 16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF,
                               16'hAAAA, 16'h5555, 1'b0, '0);
    directed_rows[8]  = mk_row(nea_pkg::ModeAcc, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF,
                               16'h8000, 16'h7FFF, 1'b0, '0);
    directed_rows[9]  = mk_row(ModeUnused, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h5555,
                               16'hAAAA, 16'h7FFF, 1'b0, '0);
    directed_rows[10] = mk_row(nea_pkg::ModeDump, '0, '0, '0, '0, '0, '0, 1'b0, '0);
    directed_rows[11] = mk_row(nea_pkg::ModeClr, '0, '0, '0, '0, '0, '0, 1'b0, '0);
    directed_rows[12] = mk_row(ModeUnused, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                               16'h8000, 16'h8000, 1'b0, '0);
    directed_rows[13] = mk_row(nea_pkg::ModeDump, '0, '0, '0, '0, '0, '0, 1'b1, 48'd0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirectedCount; i++) begin
      put_row(directed_rows[i]);
      pace();
    end

    // Two unknowns: back-to-back rows with extreme elements, dumps in between, then a clear.
    write_reg(nea_pkg::CfgRows, 3'd2);
    write_reg(nea_pkg::CfgCols, 3'd2);
    it = mk_row(nea_pkg::ModeAcc, 16'h8000, 16'h7FFF, 16'h1234, 16'hFEDC, 16'h8000, 16'h7FFF,
                1'b0, '0);
    put_row(it);
    put_row(mk_row(nea_pkg::ModeDump, '0, '0, '0, '0, '0, '0, 1'b0, '0));
    put_row(mk_row(nea_pkg::ModeAcc, 16'h8000, 16'h7FFF, '0, '0, 16'h7FFF, 16'h8000,
                   1'b0, '0));
    put_row(mk_row(nea_pkg::ModeDump, '0, '0, '0, '0, '0, '0, 1'b0, '0));
    put_row(mk_row(nea_pkg::ModeClr, '0, '0, '0, '0, '0, '0, 1'b0, '0));
    pace();

    // Random rows over a sequence of register settings, zero and oversized counts included.
    for (int p = 0; p < PhaseCount; p++) begin
      write_reg(nea_pkg::CfgRows, phase_rows[p]);
      write_reg(nea_pkg::CfgCols, {1'b0, phase_cols[p]});
      if (p == 3) write_reg(CfgUnused, 3'($urandom));
      for (int n = 0; n < RowsPerPhase; n++) begin
        put_row(rand_row());
        pace();
        if ($urandom_range(0, 24) == 0) drain();
      end
    end
    put_row(mk_row(nea_pkg::ModeDump, '0, '0, '0, '0, '0, '0, 1'b0, '0));

    drain();
    if (mismatches == 0 && dump_fifo.size() == 0) begin
      $display("normal_equations_accumulator test passed");
    end else begin
      $display("normal_equations_accumulator test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/nea_pkg.sv
rtl/core/nea_lane.sv
rtl/core/nea_dump.sv
rtl/core/normal_equations_accumulator.sv
tb/normal_equations_accumulator_tb.sv
